// ===== hdl/alp_pkg.sv =====
// ----------------------------------------------------------------------------
// alp_pkg
// Shared constants and types for the audio upsampler with low-pass filter.
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_INDEX_W     = 2;
    localparam int FRAME_CFG_W     = 24;
    localparam int SAMPLE_W        = 16;
    localparam int BYTE_W          = 8;
    localparam int ALPHA_W         = 16;
    localparam int STEP_W          = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int PROD_W          = 34;

    localparam logic [STEP_W-1:0]  MIN_STEP    = 16'd16;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RATIO   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ALPHA = 2'd2;

    // Request to the filter unit; operands hold while the unit works
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] prev;
        logic [ALPHA_W-1:0]         alpha;
    } t_lp_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] y;
    } t_lp_rsp;

endpackage

// ===== hdl/alp_lowpass.sv =====
// ----------------------------------------------------------------------------
// alp_lowpass
// One-pole filter unit: y = prev + alpha * (x - prev) / 65536,
// truncated toward zero; the product and then y are registered.
// ----------------------------------------------------------------------------
module alp_lowpass (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  alp_pkg::t_lp_req i_req,
    output alp_pkg::t_lp_rsp o_rsp
);

    localparam int SW = alp_pkg::SAMPLE_W;
    localparam int PW = alp_pkg::PROD_W;

    logic signed [SW:0]   w_diff;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_sum;
    logic signed [PW-1:0] w_prev_sh;
    logic signed [PW-17:0] w_floor;
    logic signed [PW-17:0] w_trunc;

    logic signed [PW-1:0] r_prod;
    logic                 r_prod_vld;
    logic signed [SW-1:0] r_y;
    logic                 r_done;

    always_comb begin
        w_diff  = {i_req.x[SW-1], i_req.x} - {i_req.prev[SW-1], i_req.prev};
        w_prod  = PW'($signed({1'b0, i_req.alpha}) * w_diff);
        w_prev_sh = {{(PW-SW-16){i_req.prev[SW-1]}}, i_req.prev, 16'h0000};
        w_sum   = w_prev_sh + r_prod;
        w_floor = w_sum[PW-1:16];
        // Round a negative quotient with a fraction up toward zero
        if (w_sum[PW-1] && (w_sum[15:0] != 16'h0000)) begin
            w_trunc = w_floor + (PW-16)'(1);
        end else begin
            w_trunc = w_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_req.start;
            r_done     <= r_prod_vld;
        end
        if (i_req.start) begin
            r_prod <= w_prod;
        end
        if (r_prod_vld) begin
            r_y <= w_trunc[SW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.y    = r_y;

endmodule

// ===== hdl/audio_upsample_lowpass.sv =====
// ----------------------------------------------------------------------------
// audio_upsample_lowpass
// Nearest-neighbor upsampler from 8-bit unsigned mono to 16-bit signed
// stereo frames, followed by a one-pole low-pass filter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one source byte per
//   transaction plus a start-of-sound flag that clears the frame and source
//   counters, the position accumulator and the filter history before the
//   byte is used. Output channel (o_valid / i_stall) carries one stereo
//   frame per transaction; left and right are equal, and o_last_frame marks
//   frame number frame_count - 1 of the sound.
//   Each byte yields zero to 16 frames. The block takes one byte at a time
//   and holds o_stall high until that byte's last frame has been taken.
//   With no output stall, a filtered frame passes the loop test, the
//   shared multiply/round unit, the output load and the handoff in that
//   order; the first frame of a sound skips the multiply/round unit.
//   A stalled output frame holds in the output register; the sequencer
//   waits and the input side stays stalled.
//   Reset restores step_ratio 256, frame_count 1, filter_alpha 65535 and
//   clears all counters; no clearing pass is needed.
//   Configuration writes through i_cfg_we / i_cfg_index / i_cfg_data while
//   idle; step values below 16 are used as 16.
// ----------------------------------------------------------------------------
module audio_upsample_lowpass #(
    parameter int COUNT_WIDTH = alp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [alp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [alp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // source byte channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [alp_pkg::BYTE_W-1:0]       i_sample_byte,
    input  logic                             i_start_of_sound,
    // frame channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [alp_pkg::SAMPLE_W-1:0] o_left_sample,
    output logic signed [alp_pkg::SAMPLE_W-1:0] o_right_sample,
    output logic                             o_last_frame
);

    localparam int CW  = COUNT_WIDTH;
    localparam int AW  = COUNT_WIDTH + 16;
    localparam int SW  = alp_pkg::SAMPLE_W;
    localparam int FCW = (CW < alp_pkg::FRAME_CFG_W) ? CW : alp_pkg::FRAME_CFG_W;
    localparam int NW  = $clog2(alp_pkg::MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TEST,
        S_FILT,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [alp_pkg::STEP_W-1:0]  r_step;
    logic [CW-1:0]               r_frame_count;
    logic [alp_pkg::ALPHA_W-1:0] r_alpha;

    // sound state
    logic [CW-1:0]        r_frame_index;
    logic [CW-1:0]        r_source_index;
    logic [AW-1:0]        r_pos_acc;
    logic signed [SW-1:0] r_prev;
    logic                 r_first;

    // per-byte work
    logic signed [SW-1:0] r_x;
    logic [NW-1:0]        r_nfr;
    logic                 r_lp_start;

    // output register
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_y;
    logic                 r_out_last;

    alp_pkg::t_lp_req w_lp_req;
    alp_pkg::t_lp_rsp w_lp_rsp;

    logic                 w_go;
    logic                 w_emit;
    logic signed [SW-1:0] w_y;
    logic [CW-1:0]        w_fi_next;

    assign w_lp_req.start = r_lp_start;
    assign w_lp_req.x     = r_x;
    assign w_lp_req.prev  = r_prev;
    assign w_lp_req.alpha = r_alpha;

    alp_lowpass u_lowpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lp_req),
        .o_rsp   (w_lp_rsp)
    );

    always_comb begin
        // Frame due: under the byte limit and frame_count, source position reached
        w_go = (r_nfr < NW'(alp_pkg::MAX_RESULTS))
            && (r_frame_index < r_frame_count)
            && (r_pos_acc[AW-1:8] <= {8'h00, r_source_index});
        w_emit = ((r_state == S_TEST) && w_go && r_first)
            || ((r_state == S_FILT) && w_lp_rsp.done);
        w_y       = r_first ? r_x : w_lp_rsp.y;
        w_fi_next = r_frame_index + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= alp_pkg::STEP_RESET;
            r_frame_count  <= CW'(1);
            r_alpha        <= alp_pkg::ALPHA_RESET;
            r_frame_index  <= '0;
            r_source_index <= '0;
            r_pos_acc      <= '0;
            r_prev         <= '0;
            r_first        <= 1'b1;
            r_nfr          <= '0;
            r_lp_start     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // configuration writes; saturate small steps here
            if (i_cfg_we) begin
                case (i_cfg_index)
                    alp_pkg::CFG_STEP_RATIO: begin
                        if (i_cfg_data[alp_pkg::STEP_W-1:0] < alp_pkg::MIN_STEP) begin
                            r_step <= alp_pkg::MIN_STEP;
                        end else begin
                            r_step <= i_cfg_data[alp_pkg::STEP_W-1:0];
                        end
                    end
                    alp_pkg::CFG_FRAME_COUNT: begin
                        r_frame_count <= CW'(i_cfg_data[FCW-1:0]);
                    end
                    alp_pkg::CFG_FILTER_ALPHA: begin
                        r_alpha <= i_cfg_data[alp_pkg::ALPHA_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // kick the filter unit for one cycle when a filtered frame is due
            r_lp_start <= (r_state == S_TEST) && w_go && !r_first;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // widen: b * 257 - 32768 is {b, b} with the sign bit flipped
                        r_x   <= {~i_sample_byte[alp_pkg::BYTE_W-1],
                                  i_sample_byte[alp_pkg::BYTE_W-2:0], i_sample_byte};
                        r_nfr <= '0;
                        if (i_start_of_sound) begin
                            r_frame_index  <= '0;
                            r_source_index <= '0;
                            r_pos_acc      <= '0;
                            r_prev         <= '0;
                            r_first        <= 1'b1;
                        end
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (w_go) begin
                        if (r_first) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FILT;
                        end
                    end else begin
                        // byte done: advance the source index, saturating
                        if (r_source_index != {CW{1'b1}}) begin
                            r_source_index <= r_source_index + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FILT: begin
                    if (w_lp_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_TEST;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // load a frame and advance the sound counters
            if (w_emit) begin
                r_out_valid   <= 1'b1;
                r_out_y       <= w_y;
                r_out_last    <= (w_fi_next == r_frame_count);
                r_prev        <= w_y;
                r_first       <= 1'b0;
                r_frame_index <= w_fi_next;
                r_pos_acc     <= r_pos_acc + AW'(r_step);
                r_nfr         <= r_nfr + NW'(1);
            end
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_left_sample  = r_out_y;
    assign o_right_sample = r_out_y;
    assign o_last_frame   = r_out_last;

    // A pending frame always keeps the input side closed
    a_out_blocks_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("frame pending while input accepted");

    // The frame counter never passes the configured count within a sound
    a_frame_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_frame_index <= r_frame_count))
        else $error("frame index passed frame count");

    // No byte yields more than the frame limit
    a_frame_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfr <= NW'(alp_pkg::MAX_RESULTS))
        else $error("too many frames for one byte");

    // A filter result only arrives while the sequencer waits for it
    a_filter_handoff : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lp_rsp.done |-> (r_state == S_FILT))
        else $error("filter result outside wait state");

endmodule

// ===== tb/audio_upsample_lowpass_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_upsample_lowpass_tb
// Self-checking bench for the nearest-neighbor upsampler with one-pole
// low-pass. A clocked driver feeds source bytes from a queue and predicts
// the stereo frames each accepted byte must produce; a clocked monitor
// compares every frame taken from the block against the oldest prediction.
// Directed sounds cover the register extremes and corner cases, then
// randomized sounds run under several register settings with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------
module audio_upsample_lowpass_tb;

    localparam int     CNT_W           = alp_pkg::COUNT_WIDTH_DEF;
    localparam int     BYTE_W          = alp_pkg::BYTE_W;
    localparam int     SAMPLE_W        = alp_pkg::SAMPLE_W;
    localparam int     CFG_INDEX_W     = alp_pkg::CFG_INDEX_W;
    localparam int     CFG_DATA_W      = alp_pkg::CFG_DATA_W;
    localparam int     STEP_W          = alp_pkg::STEP_W;
    localparam int     FRAME_CFG_W     = alp_pkg::FRAME_CFG_W;
    localparam int     ALPHA_W         = alp_pkg::ALPHA_W;
    localparam int     MAX_RESULTS     = alp_pkg::MAX_RESULTS;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     RAND_PHASES     = 8;
    localparam int     BYTES_PER_PHASE = 22;
    localparam int     REPORT_LIMIT    = 10;
    localparam longint TIMEOUT_NS      = 30_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0] sample;
        logic              sos;
    } t_src_byte;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } t_stereo_frame;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_cfg_we         = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index      = alp_pkg::CFG_STEP_RATIO;
    logic [CFG_DATA_W-1:0]      i_cfg_data       = '0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic [BYTE_W-1:0]          i_sample_byte    = '0;
    logic                       i_start_of_sound = 1'b0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    logic signed [SAMPLE_W-1:0] o_left_sample;
    logic signed [SAMPLE_W-1:0] o_right_sample;
    logic                       o_last_frame;

    audio_upsample_lowpass #(
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_byte    (i_sample_byte),
        .i_start_of_sound (i_start_of_sound),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_left_sample    (o_left_sample),
        .o_right_sample   (o_right_sample),
        .o_last_frame     (o_last_frame)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_src_byte     bytes_pending[$];   // bytes not yet offered to the block
    t_stereo_frame frames_due[$];      // predicted frames, oldest first
    int            items_queued   = 0;
    int            items_accepted = 0;
    int            frames_seen    = 0;
    int            mismatches     = 0;
    int            src_gap        = 0;
    int            snk_run        = 0;
    int            hold_left      = 0;
    bit            hold_kick      = 1'b0;
    bit            hold_seen      = 1'b0;
    bit            src_idle_en    = 1'b1;
    bit            snk_idle_en    = 1'b1;

    // Shadow registers and sound state of the predictor
    logic [STEP_W-1:0]      reg_step;
    logic [FRAME_CFG_W-1:0] reg_frames;
    logic [ALPHA_W-1:0]     reg_alpha;
    logic [CNT_W-1:0]       snd_frame_idx;
    logic [CNT_W-1:0]       snd_src_idx;
    logic [CNT_W+15:0]      snd_pos;        // Q32.8 position of the next frame
    int                     snd_prev;
    bit                     snd_first;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops frames.
    initial begin
        #(TIMEOUT_NS);
        $display("audio_upsample_lowpass: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_sound();
        snd_frame_idx = '0;
        snd_src_idx   = '0;
        snd_pos       = '0;
        snd_prev      = 0;
        snd_first     = 1'b1;
    endtask

    // Work out every frame one source byte yields and queue them.
    task automatic resample_and_filter(input logic [BYTE_W-1:0] b, input logic sos);
        logic [STEP_W-1:0] step_eff;
        int                x;
        int                y;
        int                n;
        longint            acc;
        t_stereo_frame     f;
        step_eff = (reg_step < alp_pkg::MIN_STEP) ? alp_pkg::MIN_STEP : reg_step;
        // widen the unsigned byte to full-scale signed 16 bits
        x = int'(b) * 257 - 32768;
        if (sos)
            clear_sound();
        n = 0;
        while (n < MAX_RESULTS && snd_frame_idx < reg_frames &&
               (snd_pos >> 8) <= (CNT_W+16)'(snd_src_idx)) begin
            if (snd_first) begin
                // first frame of a sound passes straight through
                y = x;
                snd_first = 1'b0;
            end else begin
                acc = longint'(reg_alpha) * x + (65536 - longint'(reg_alpha)) * snd_prev;
                y = int'(acc / 65536);   // truncates toward zero
            end
            f.left  = y[SAMPLE_W-1:0];
            f.right = y[SAMPLE_W-1:0];
            f.last  = (32'(snd_frame_idx) + 1 == 32'(reg_frames));
            frames_due.push_back(f);
            snd_prev      = y;
            snd_frame_idx = snd_frame_idx + CNT_W'(1);
            snd_pos       = snd_pos + (CNT_W+16)'(step_eff);
            n++;
        end
        // source index saturates instead of wrapping
        if (snd_src_idx != '1)
            snd_src_idx = snd_src_idx + CNT_W'(1);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit en);
        int r;
        if (!en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Source driver: offer queued bytes, hold each until it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : src_drive
        t_src_byte nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap <= 0;
        end else if (!(i_valid && o_stall)) begin
            // a transaction completes here when valid was up
            if (i_valid) begin
                resample_and_filter(i_sample_byte, i_start_of_sound);
                items_accepted++;
            end
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (bytes_pending.size() != 0) begin
                nxt = bytes_pending.pop_front();
                i_valid          <= 1'b1;
                i_sample_byte    <= nxt.sample;
                i_start_of_sound <= nxt.sos;
                src_gap          <= pick_gap(src_idle_en);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off: counts down on its own after each kick
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_kick != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_kick;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Frame monitor: check each taken frame, drive random stalls
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input t_stereo_frame want,
                                 input t_stereo_frame got);
        if (mismatches < REPORT_LIMIT)
            $display("frame %0d %s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     frames_seen, what, want.left, want.right, want.last,
                     got.left, got.right, got.last);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : frame_check
        t_stereo_frame got;
        t_stereo_frame want;
        logic          stall_next;
        int            run;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            snk_run <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.left  = o_left_sample;
                got.right = o_right_sample;
                got.last  = o_last_frame;
                if (frames_due.size() == 0) begin
                    note_mismatch("unexpected", '0, got);
                end else begin
                    want = frames_due.pop_front();
                    if (got.left !== want.left || got.right !== want.right ||
                        got.last !== want.last)
                        note_mismatch("wrong", want, got);
                end
                frames_seen++;
            end
            if (snk_run != 0) begin
                snk_run    <= snk_run - 1;
                stall_next = 1'b1;
            end else begin
                run        = pick_gap(snk_idle_en);
                stall_next = (run != 0);
                if (run != 0)
                    snk_run <= run - 1;
            end
            i_stall <= stall_next || (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic sos, input logic [BYTE_W-1:0] b);
        t_src_byte item;
        item.sample = b;
        item.sos    = sos;
        bytes_pending.push_back(item);
        items_queued++;
    endtask

    // Wait for every byte to be taken and every frame to arrive, then let
    // a byte that yields no frame finish inside the block.
    task automatic drain();
        do
            @(negedge i_clk);
        while (!(items_accepted == items_queued && frames_due.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            alp_pkg::CFG_STEP_RATIO:   reg_step   = data[STEP_W-1:0];
            alp_pkg::CFG_FRAME_COUNT:  reg_frames = data[FRAME_CFG_W-1:0];
            alp_pkg::CFG_FILTER_ALPHA: reg_alpha  = data[ALPHA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] step_d,
                             input logic [CFG_DATA_W-1:0] frames_d,
                             input logic [CFG_DATA_W-1:0] alpha_d);
        write_reg(alp_pkg::CFG_STEP_RATIO, step_d);
        write_reg(alp_pkg::CFG_FRAME_COUNT, frames_d);
        write_reg(alp_pkg::CFG_FILTER_ALPHA, alpha_d);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                     left_in_sound;
        logic                   sos;
        logic [STEP_W-1:0]      step_v;
        logic [FRAME_CFG_W-1:0] frames_v;
        logic [ALPHA_W-1:0]     alpha_v;

        reg_step   = alp_pkg::STEP_RESET;
        reg_frames = FRAME_CFG_W'(1);
        reg_alpha  = alp_pkg::ALPHA_RESET;
        clear_sound();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one frame per sound, marked last; later bytes of
        // the finished sound yield nothing until the next start.
        queue_byte(1'b1, 8'h00);
        queue_byte(1'b0, 8'hFF);
        queue_byte(1'b1, 8'h80);
        drain();

        // Step of zero runs at the minimum step; bytes fill the sixteen-frame
        // limit until frame 40. Upper data bits must be dropped. Alpha of
        // zero freezes the filter on the first value.
        configure({8'hA5, 16'd0}, 24'd40, {8'h5A, 16'd0});
        queue_byte(1'b1, 8'hFF);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h80);
        drain();

        // Zero frame count: nothing comes out at all.
        configure(24'd16, 24'd0, 24'h00FFFF);
        queue_byte(1'b1, 8'h77);
        queue_byte(1'b0, 8'hC8);
        drain();

        // Largest step and frame count: only the first frame of the sound.
        configure(24'h00FFFF, 24'hFFFFFF, 24'h008000);
        queue_byte(1'b1, 8'hFF);
        queue_byte(1'b0, 8'h00);
        queue_byte(1'b0, 8'h01);
        queue_byte(1'b0, 8'hFE);
        drain();

        // Step changed mid-sound: the position carries over, then the new
        // step applies; the sound runs out on its marked last frame.
        configure(24'd128, 24'd10, 24'd1234);
        queue_byte(1'b1, 8'h10);
        queue_byte(1'b0, 8'h20);
        queue_byte(1'b0, 8'h30);
        drain();
        configure(24'd512, 24'd10, 24'd1234);
        queue_byte(1'b0, 8'h40);
        queue_byte(1'b0, 8'h50);
        queue_byte(1'b0, 8'h60);
        queue_byte(1'b0, 8'h70);
        queue_byte(1'b0, 8'h80);
        queue_byte(1'b0, 8'h90);
        queue_byte(1'b0, 8'hA0);
        queue_byte(1'b0, 8'hB0);
        drain();

        // Random sounds under a spread of register settings. Sounds may
        // run across a setting change; a few restart early.
        left_in_sound = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            alpha_v = ALPHA_W'($urandom_range(0, 65535));
            case (ph)
                0: begin
                    step_v   = STEP_W'($urandom_range(0, 15));
                    frames_v = FRAME_CFG_W'($urandom_range(8, 64));
                end
                1: begin
                    step_v   = STEP_W'($urandom_range(16, 128));
                    frames_v = FRAME_CFG_W'($urandom_range(1, 40));
                    alpha_v  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                2: begin
                    step_v   = STEP_W'($urandom_range(128, 512));
                    frames_v = FRAME_CFG_W'($urandom_range(1, 16));
                end
                3: begin
                    step_v   = STEP_W'($urandom_range(512, 65535));
                    frames_v = $urandom_range(0, 1) ? 24'hFFFFFF :
                               FRAME_CFG_W'($urandom_range(1, 8));
                end
                4: begin
                    step_v   = STEP_W'($urandom_range(0, 65535));
                    frames_v = FRAME_CFG_W'($urandom_range(0, 3));
                end
                default: begin
                    step_v   = STEP_W'($urandom_range(32, 768));
                    frames_v = FRAME_CFG_W'($urandom_range(1, 100));
                end
            endcase
            src_idle_en = (ph != 2);
            snk_idle_en = (ph != 3);
            configure({8'($urandom_range(0, 255)), step_v}, frames_v,
                      {8'($urandom_range(0, 255)), alpha_v});
            // Block the frame side for a long stretch while bytes keep
            // coming, so the block backs up and stalls its input.
            if (ph == 0 || ph == 5)
                hold_kick <= ~hold_kick;
            for (int k = 0; k < BYTES_PER_PHASE; k++) begin
                sos = 1'b0;
                if (left_in_sound == 0 || $urandom_range(0, 19) == 0) begin
                    sos           = 1'b1;
                    left_in_sound = $urandom_range(1, 12);
                end
                left_in_sound--;
                queue_byte(sos, 8'($urandom));
            end
            drain();
        end

        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("audio_upsample_lowpass: match");
        end else begin
            $display("audio_upsample_lowpass: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/alp_pkg.sv
hdl/alp_lowpass.sv
hdl/audio_upsample_lowpass.sv
tb/audio_upsample_lowpass_tb.sv
